// File: rtl/assert_macros.svh
// Assertion helpers shared by the decoder modules.
// All checks are clocked on the rising edge and are disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When the condition holds, the consequence must hold in the following cycle.
`define ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

// File: rtl/b64d_pkg.sv
package b64d_pkg;

   localparam int QueueDepthDefault = 4;

   localparam logic [7:0] UpperFirst = 8'h41;  // 'A'
   localparam logic [7:0] UpperLast  = 8'h5A;  // 'Z'
   localparam logic [7:0] LowerFirst = 8'h61;  // 'a'
   localparam logic [7:0] LowerLast  = 8'h7A;  // 'z'
   localparam logic [7:0] DigitFirst = 8'h30;  // '0'
   localparam logic [7:0] DigitLast  = 8'h39;  // '9'
   localparam logic [7:0] PlusChar   = 8'h2B;  // '+'
   localparam logic [7:0] SlashChar  = 8'h2F;  // '/'
   localparam logic [7:0] PadChar    = 8'h3D;  // '='

   // Offsets that take a character code to its sextet, modulo 256.
   localparam logic [7:0] UpperOffset = 8'h41;  // 'A' -> 0
   localparam logic [7:0] LowerOffset = 8'h47;  // 'a' -> 26
   localparam logic [7:0] DigitOffset = 8'hFC;  // '0' -> 52
   localparam logic [5:0] PlusValue   = 6'd62;
   localparam logic [5:0] SlashValue  = 6'd63;

   typedef struct packed {
      logic [7:0] char_code;
      logic       message_end;
   } req_item_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       run_last;
   } rsp_item_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } sextet_type;

   // Up to three decoded bytes of one item; bytes[0] goes out first.
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      last_idx;
   } packet_type;

   function automatic sextet_type decode_char(input logic [7:0] c);
      sextet_type s;
      logic [7:0] d;
      s = '0;
      d = '0;
      case (c) inside
         [UpperFirst:UpperLast]: begin
            d = c - UpperOffset;
            s = '{valid: 1'b1, value: d[5:0]};
         end
         [LowerFirst:LowerLast]: begin
            d = c - LowerOffset;
            s = '{valid: 1'b1, value: d[5:0]};
         end
         [DigitFirst:DigitLast]: begin
            d = c - DigitOffset;
            s = '{valid: 1'b1, value: d[5:0]};
         end
         PlusChar:  s = '{valid: 1'b1, value: PlusValue};
         SlashChar: s = '{valid: 1'b1, value: SlashValue};
         PadChar:   s = '0;
         default:   s = '0;
      endcase
      return s;
   endfunction

   // Four sextets, most significant bits first, make three bytes.
   function automatic logic [2:0][7:0] pack_group(input logic [5:0] s0, input logic [5:0] s1,
                                                  input logic [5:0] s2, input logic [5:0] s3);
      logic [2:0][7:0] b;
      b[0] = {s0, s1[5:4]};
      b[1] = {s1[3:0], s2[5:2]};
      b[2] = {s2[1:0], s3};
      return b;
   endfunction

endpackage

// File: rtl/b64d_front.sv
`include "assert_macros.svh"

module b64d_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  b64d_pkg::req_item_type req_item,
   input  logic                   queue_full,
   output logic                   push,
   output b64d_pkg::packet_type   push_packet
);

   logic [1:0]       fill_ff, fill_in;
   logic [2:0][5:0]  held_ff, held_in;
   logic             halted_ff, halted_in;

   logic                  accept;
   b64d_pkg::sextet_type  sx;
   logic [2:0][5:0]       merged;
   logic [1:0]            n_bytes;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign sx        = b64d_pkg::decode_char(req_item.char_code);

   always_comb begin
      // The held sextets with the new one dropped into its slot, so that a
      // flush at message end sees it.
      for (int i = 0; i < 3; i++) begin
         merged[i] = (sx.valid && fill_ff == 2'(i)) ? sx.value : held_ff[i];
      end

      if (halted_ff) begin
         n_bytes = 2'd0;
      end else if (!sx.valid) begin
         n_bytes = (fill_ff >= 2'd2) ? fill_ff - 2'd1 : 2'd0;
      end else if (fill_ff == 2'd3) begin
         n_bytes = 2'd3;
      end else if (req_item.message_end) begin
         n_bytes = fill_ff;
      end else begin
         n_bytes = 2'd0;
      end

      push_packet.bytes    = b64d_pkg::pack_group(merged[0], merged[1], merged[2], sx.value);
      push_packet.last_idx = n_bytes - 2'd1;
      push                 = accept && (n_bytes != 2'd0);

      fill_in   = fill_ff;
      held_in   = held_ff;
      halted_in = halted_ff;
      if (accept) begin
         if (req_item.message_end) begin
            fill_in   = '0;
            held_in   = '0;
            halted_in = 1'b0;
         end else if (!halted_ff) begin
            if (!sx.valid) begin
               fill_in   = '0;
               halted_in = 1'b1;
            end else if (fill_ff == 2'd3) begin
               fill_in = '0;
            end else begin
               held_in = merged;
               fill_in = fill_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         held_ff   <= '0;
         halted_ff <= 1'b0;
      end else begin
         fill_ff   <= fill_in;
         held_ff   <= held_in;
         halted_ff <= halted_in;
      end
   end

   `ASSERT_ALWAYS(a_halted_silent, clock, reset, !(halted_ff && push), "push while halted")
   `ASSERT_NEXT(a_end_clears, clock, reset, accept && req_item.message_end, fill_ff == 2'd0 && !halted_ff, "message end left state behind")

endmodule

// File: rtl/b64d_queue.sv
`include "assert_macros.svh"

module b64d_queue #(
   parameter int QueueDepth = b64d_pkg::QueueDepthDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  b64d_pkg::packet_type push_packet,
   output logic                 full,
   output logic                 not_empty,
   output b64d_pkg::packet_type head,
   input  logic                 pop
);

   localparam int PtrW = $clog2(QueueDepth);
   localparam int CntW = $clog2(QueueDepth + 1);

   b64d_pkg::packet_type store_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full      = (count_ff == CntW'(QueueDepth));
   assign not_empty = (count_ff != '0);
   assign head      = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_packet;
      end
   end

   `ASSERT_ALWAYS(a_no_overflow, clock, reset, !(push && full), "push into a full queue")
   `ASSERT_ALWAYS(a_no_underflow, clock, reset, !(pop && !not_empty), "pop from an empty queue")

endmodule

// File: rtl/b64d_back.sv
`include "assert_macros.svh"

module b64d_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   not_empty,
   input  b64d_pkg::packet_type   head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output b64d_pkg::rsp_item_type rsp_item
);

   logic [1:0] idx_ff, idx_in;
   logic       last;

   assign rsp_valid          = not_empty;
   assign last               = (idx_ff == head.last_idx);
   assign rsp_item.data_byte = head.bytes[idx_ff];
   assign rsp_item.run_last  = last;
   assign pop                = rsp_valid && !rsp_stall && last;

   always_comb begin
      idx_in = idx_ff;
      if (rsp_valid && !rsp_stall) begin
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   `ASSERT_ALWAYS(a_idx_in_packet, clock, reset, !not_empty || idx_ff <= head.last_idx, "byte index beyond packet")

endmodule

// File: rtl/base64_stream_decoder.sv
// Streaming base64 decoder for the standard alphabet (A-Z, a-z, 0-9, '+', '/'). Each input
// item is one character; every fourth valid character releases three bytes, most significant
// bits first. A pad '=' or any byte outside the alphabet flushes the partial group (k held
// sextets give k-1 bytes) and halts decoding until the item flagged message_end, which also
// flushes what is held and clears all state. Each result item is one byte, and run_last marks
// the last byte that a given input item produced. The front accepts one character every cycle
// while the packet queue has room; the back emits one byte per cycle while rsp_stall is low, so
// an item that yields three bytes holds the output side until all three are taken. Typical
// text (four characters per three bytes) therefore streams at one character per cycle, and input
// stalls only when the back, limited to one byte per cycle, lets the QueueDepth-entry queue fill.
// Bytes are registered in the queue before they are offered. QueueDepth must be at least 2.
module base64_stream_decoder #(
   parameter int QueueDepth = b64d_pkg::QueueDepthDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  b64d_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output b64d_pkg::rsp_item_type rsp_item
);

   logic                 push;
   b64d_pkg::packet_type push_packet;
   logic                 queue_full;
   logic                 not_empty;
   b64d_pkg::packet_type head;
   logic                 pop;

   // Front: decodes the character, keeps the group state and builds a packet of bytes.
   b64d_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .queue_full  (queue_full),
      .push        (push),
      .push_packet (push_packet)
   );

   // Packet queue that lets the front keep taking characters while bytes drain.
   b64d_queue #(
      .QueueDepth (QueueDepth)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_packet (push_packet),
      .full        (queue_full),
      .not_empty   (not_empty),
      .head        (head),
      .pop         (pop)
   );

   // Back: walks the head packet one byte per item and releases it after the last byte.
   b64d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
